// ----- hw/rtl/lsp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared constants and types of the lidar scan packet parser.
// ----------------------------------------------------------------------------
package lsp_pkg;

    localparam int SAMPLES_PER_PACKET_DEF = 22;
    localparam int SECTOR_COUNT_DEF       = 16;

    localparam int SECTOR_SPAN = 2250;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h00;
    localparam logic [7:0] MARK_FIRST  = 8'h61;
    localparam logic [7:0] MARK_SECOND = 8'hAD;

    localparam logic [15:0] MIN_DIST_RESET     = 16'd2;
    localparam logic [15:0] INVALID_CODE_RESET = 16'd250;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DIST     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INVALID_CODE = 2'd1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_PACKET = 1'b1;

    localparam int OUT_TDATA_W = 128;

    typedef struct packed {
        logic               kind;
        logic [31:0]        packet_count;
        logic signed [7:0]  payload_count;
        logic [15:0]        start_angle;
        logic [15:0]        angle_offset;
        logic [7:0]         scan_speed;
        logic [7:0]         version_byte;
        logic [15:0]        range_value;
        logic [7:0]         signal_strength;
        logic               index_valid;
        logic [8:0]         sample_index;
    } result_t;

    typedef struct packed {
        logic [15:0] min_valid_distance;
        logic [15:0] invalid_distance_code;
    } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lsp_index.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_index
// Maps the start angle and sample number to a sample index and its flag.
// ----------------------------------------------------------------------------
module lsp_index
    import lsp_pkg::*;
#(
    parameter int SAMPLES_PER_PACKET = SAMPLES_PER_PACKET_DEF,
    parameter int SECTOR_COUNT       = SECTOR_COUNT_DEF,
    parameter int K_W                = 5
) (
    input  wire logic [15:0]    start_angle,
    input  wire logic [K_W-1:0] sample_num,
    output logic [8:0]          sample_index,
    output logic                index_valid
);

    localparam logic [16:0] VALID_LIMIT = 17'(SECTOR_COUNT * SECTOR_SPAN);

    logic [3:0] sector;
    logic [9:0] index_wide;

    always_comb begin
        sector = 4'd0;
        for (int i = 1; i < SECTOR_COUNT; i++) begin
            if (start_angle >= 16'(i * SECTOR_SPAN)) begin
                sector = 4'(i);
            end
        end
    end

    assign index_valid  = {1'b0, start_angle} < VALID_LIMIT;
    assign index_wide   = 10'(sector) * 10'(SAMPLES_PER_PACKET) + 10'(sample_num);
    assign sample_index = index_valid ? index_wide[8:0] : 9'd0;

endmodule
`default_nettype wire

// ----- hw/rtl/lsp_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_parser
// Byte-position parser: header fields, sample assembly and packet count.
// ----------------------------------------------------------------------------
module lsp_parser
    import lsp_pkg::*;
#(
    parameter int SAMPLES_PER_PACKET = SAMPLES_PER_PACKET_DEF,
    parameter int SECTOR_COUNT       = SECTOR_COUNT_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    input  wire cfg_t       cfg,
    output logic            emit,
    output result_t         result
);

    localparam int K_W = (SAMPLES_PER_PACKET > 1) ? $clog2(SAMPLES_PER_PACKET) : 1;
    localparam logic [K_W-1:0] LAST_SAMPLE = K_W'(SAMPLES_PER_PACKET - 1);

    localparam logic [3:0] HP_SYNC0    = 4'd0;
    localparam logic [3:0] HP_SYNC1    = 4'd1;
    localparam logic [3:0] HP_ANY      = 4'd2;
    localparam logic [3:0] HP_VERSION  = 4'd3;
    localparam logic [3:0] HP_MARK0    = 4'd4;
    localparam logic [3:0] HP_MARK1    = 4'd5;
    localparam logic [3:0] HP_SKIP     = 4'd6;
    localparam logic [3:0] HP_LENGTH   = 4'd7;
    localparam logic [3:0] HP_SPEED    = 4'd8;
    localparam logic [3:0] HP_OFS_HI   = 4'd9;
    localparam logic [3:0] HP_OFS_LO   = 4'd10;
    localparam logic [3:0] HP_START_HI = 4'd11;
    localparam logic [3:0] HP_START_LO = 4'd12;

    localparam logic [2:0] SP_SIGNAL  = 3'd0;
    localparam logic [2:0] SP_DIST_HI = 3'd1;
    localparam logic [2:0] SP_DIST_LO = 3'd2;
    localparam logic [2:0] SP_LAST    = 3'd5;

    typedef enum logic [1:0] {
        ST_HDR,
        ST_SMP,
        ST_TRL
    } state_t;

    state_t            state_reg, state_next;
    logic [3:0]        hdr_pos_reg, hdr_pos_next;
    logic [2:0]        phase_reg, phase_next;
    logic [K_W-1:0]    num_reg, num_next;
    logic              trl_pos_reg, trl_pos_next;
    logic [7:0]        version_reg, version_next;
    logic [7:0]        speed_reg, speed_next;
    logic [15:0]       offset_reg, offset_next;
    logic [15:0]       start_reg, start_next;
    logic [7:0]        length_reg, length_next;
    logic [7:0]        signal_reg, signal_next;
    logic [7:0]        dist_hi_reg, dist_hi_next;
    logic [31:0]       packets_reg, packets_next;

    logic [8:0]  sample_index;
    logic        index_valid;
    logic [15:0] dist_value;
    logic        emit_sample;
    logic        emit_packet;

    function automatic logic [7:0] length_to_count(input logic [7:0] b);
        logic [7:0]  d;
        logic [15:0] prod;
        d    = b - 8'd5;
        prod = 16'(d) * 16'd171;
        if (b >= 8'd5) begin
            length_to_count = 8'(prod >> 9);
        end else if (b <= 8'd2) begin
            length_to_count = 8'hFF;
        end else begin
            length_to_count = 8'd0;
        end
    endfunction

    lsp_index #(
        .SAMPLES_PER_PACKET(SAMPLES_PER_PACKET),
        .SECTOR_COUNT      (SECTOR_COUNT),
        .K_W               (K_W)
    ) u_index (
        .start_angle (start_reg),
        .sample_num  (num_reg),
        .sample_index(sample_index),
        .index_valid (index_valid)
    );

    assign emit_sample = (state_reg == ST_SMP) && (phase_reg == SP_DIST_LO);
    assign emit_packet = (state_reg == ST_TRL) && trl_pos_reg;
    assign emit        = emit_sample || emit_packet;

    always_comb begin
        dist_value = {dist_hi_reg, rx_byte};
        if (dist_value <= cfg.min_valid_distance) begin
            dist_value = cfg.invalid_distance_code;
        end
    end

    always_comb begin
        result.kind            = emit_packet ? KIND_PACKET : KIND_SAMPLE;
        result.packet_count    = emit_packet ? packets_reg + 32'd1 : packets_reg;
        result.payload_count   = length_reg;
        result.start_angle     = start_reg;
        result.angle_offset    = offset_reg;
        result.scan_speed      = speed_reg;
        result.version_byte    = version_reg;
        result.range_value     = emit_packet ? 16'd0 : dist_value;
        result.signal_strength = emit_packet ? 8'd0 : signal_reg;
        result.index_valid     = emit_packet ? 1'b0 : index_valid;
        result.sample_index    = emit_packet ? 9'd0 : sample_index;
    end

    always_comb begin
        state_next   = state_reg;
        hdr_pos_next = hdr_pos_reg;
        phase_next   = phase_reg;
        num_next     = num_reg;
        trl_pos_next = trl_pos_reg;
        version_next = version_reg;
        speed_next   = speed_reg;
        offset_next  = offset_reg;
        start_next   = start_reg;
        length_next  = length_reg;
        signal_next  = signal_reg;
        dist_hi_next = dist_hi_reg;
        packets_next = packets_reg;
        case (state_reg)
            ST_HDR: begin
                hdr_pos_next = hdr_pos_reg + 4'd1;
                case (hdr_pos_reg)
                    HP_SYNC0: begin
                        if (rx_byte != SYNC_FIRST) hdr_pos_next = HP_SYNC0;
                    end
                    HP_SYNC1: begin
                        if (rx_byte != SYNC_SECOND) hdr_pos_next = HP_SYNC0;
                    end
                    HP_ANY, HP_SKIP: begin
                    end
                    HP_VERSION: version_next = rx_byte;
                    HP_MARK0: begin
                        if (rx_byte != MARK_FIRST) hdr_pos_next = HP_SYNC0;
                    end
                    HP_MARK1: begin
                        if (rx_byte != MARK_SECOND) hdr_pos_next = HP_SYNC0;
                    end
                    HP_LENGTH:   length_next = length_to_count(rx_byte);
                    HP_SPEED:    speed_next = rx_byte;
                    HP_OFS_HI:   offset_next[15:8] = rx_byte;
                    HP_OFS_LO:   offset_next[7:0] = rx_byte;
                    HP_START_HI: start_next[15:8] = rx_byte;
                    HP_START_LO: begin
                        start_next[7:0] = rx_byte;
                        hdr_pos_next    = HP_SYNC0;
                        state_next      = ST_SMP;
                        phase_next      = SP_SIGNAL;
                        num_next        = '0;
                    end
                    default: hdr_pos_next = HP_SYNC0;
                endcase
            end
            ST_SMP: begin
                phase_next = phase_reg + 3'd1;
                if (phase_reg == SP_SIGNAL) signal_next = rx_byte;
                if (phase_reg == SP_DIST_HI) dist_hi_next = rx_byte;
                if (phase_reg >= SP_LAST) begin
                    phase_next = SP_SIGNAL;
                    if (num_reg == LAST_SAMPLE) begin
                        state_next   = ST_TRL;
                        trl_pos_next = 1'b0;
                    end else begin
                        num_next = num_reg + K_W'(1);
                    end
                end
            end
            ST_TRL: begin
                trl_pos_next = 1'b1;
                if (trl_pos_reg) begin
                    packets_next = packets_reg + 32'd1;
                    state_next   = ST_HDR;
                    hdr_pos_next = HP_SYNC0;
                    trl_pos_next = 1'b0;
                end
            end
            default: begin
                state_next   = ST_HDR;
                hdr_pos_next = HP_SYNC0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_HDR;
            hdr_pos_reg <= HP_SYNC0;
            phase_reg   <= SP_SIGNAL;
            num_reg     <= '0;
            trl_pos_reg <= 1'b0;
            version_reg <= 8'd0;
            speed_reg   <= 8'd0;
            offset_reg  <= 16'd0;
            start_reg   <= 16'd0;
            length_reg  <= 8'd0;
            signal_reg  <= 8'd0;
            dist_hi_reg <= 8'd0;
            packets_reg <= 32'd0;
        end else if (step) begin
            state_reg   <= state_next;
            hdr_pos_reg <= hdr_pos_next;
            phase_reg   <= phase_next;
            num_reg     <= num_next;
            trl_pos_reg <= trl_pos_next;
            version_reg <= version_next;
            speed_reg   <= speed_next;
            offset_reg  <= offset_next;
            start_reg   <= start_next;
            length_reg  <= length_next;
            signal_reg  <= signal_next;
            dist_hi_reg <= dist_hi_next;
            packets_reg <= packets_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lidar_scan_packet_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_scan_packet_parser
// Parses a lidar serial byte stream into sample and packet-done requests.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_tvalid/s_tready  | s_tdata: rx_byte
//   m_      | out       | m_tvalid/m_tready  | m_tdata: result fields, m_tuser: kind
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte is taken per cycle unless a result stalls; each result is registered.
// The input register and the result register each hold one request, so one
// byte is still taken while a result waits on m_tready.
// A stalled result holds the parser only on bytes that would emit a result.
// Synchronous reset clears the parser, the counter and both valid flags.
// ----------------------------------------------------------------------------
module lidar_scan_packet_parser
    import lsp_pkg::*;
#(
    parameter int SAMPLES_PER_PACKET = SAMPLES_PER_PACKET_DEF,
    parameter int SECTOR_COUNT       = SECTOR_COUNT_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [8:0] sample_index, [9] index_valid, [17:10] signal_strength,
    // [33:18] range_value, [41:34] version_byte, [49:42] scan_speed,
    // [65:50] angle_offset, [81:66] start_angle, [89:82] payload_count,
    // [121:90] packet_count, [127:122] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic [0:0]                  m_tuser,   // [0] kind
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]            cfg_data
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    cfg_t       cfg_reg;

    logic    emit;
    result_t result;
    logic    advance;

    assign advance   = in_valid_reg && (!emit || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    lsp_parser #(
        .SAMPLES_PER_PACKET(SAMPLES_PER_PACKET),
        .SECTOR_COUNT      (SECTOR_COUNT)
    ) u_parser (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (advance),
        .rx_byte(in_byte_reg),
        .cfg    (cfg_reg),
        .emit   (emit),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.min_valid_distance    <= MIN_DIST_RESET;
            cfg_reg.invalid_distance_code <= INVALID_CODE_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_DIST:     cfg_reg.min_valid_distance <= cfg_data;
                    REG_INVALID_CODE: cfg_reg.invalid_distance_code <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && emit) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'd0, out_reg.packet_count, out_reg.payload_count,
                       out_reg.start_angle, out_reg.angle_offset, out_reg.scan_speed,
                       out_reg.version_byte, out_reg.range_value,
                       out_reg.signal_strength, out_reg.index_valid,
                       out_reg.sample_index};

`ifndef SYNTHESIS
    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("Input stalled with an empty input register.");

    a_held_byte_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && emit && out_valid_reg && !m_tready |=>
            in_valid_reg && $stable(in_byte_reg))
        else $error("Byte lost while its result was blocked.");

    a_invalid_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.index_valid |-> out_reg.sample_index == 9'd0)
        else $error("Invalid sector with a nonzero sample index.");

    a_packet_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.kind == KIND_PACKET |->
            !out_reg.index_valid && out_reg.range_value == 16'd0
            && out_reg.signal_strength == 8'd0)
        else $error("Packet-done request carries sample fields.");
`endif

endmodule
`default_nettype wire
